[src/toy_cpu_execute_unit_core_assert.svh]
`ifndef TOY_CPU_EXECUTE_UNIT_CORE_ASSERT_SVH
`define TOY_CPU_EXECUTE_UNIT_CORE_ASSERT_SVH

// same-cycle implication, checked on every clock edge out of reset
`define TCPU_ASSERT_IMPLY(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define TCPU_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[src/tcpu_pkg.sv]
`timescale 1ns / 1ps

package tcpu_pkg;

  localparam int OP_W          = 4;
  localparam int REG_W         = 4;
  localparam int DATA_W        = 32;
  localparam int BYTE_W        = 8;
  localparam int REASON_W      = 3;
  localparam int NUM_BYTE_REGS = 4;
  localparam int NUM_WIDE_REGS = 6;
  localparam int BIDX_W        = 2;
  localparam int WIDX_W        = 3;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [OP_W-1:0] OP_SET   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUM   = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd2;
  localparam logic [OP_W-1:0] OP_JNZ   = 4'd3;
  localparam logic [OP_W-1:0] OP_SLEEP = 4'd4;
  localparam logic [OP_W-1:0] OP_EXIT  = 4'd10;

  localparam logic [REG_W-1:0] REG_AX  = 4'd0;
  localparam logic [REG_W-1:0] REG_EAX = 4'd4;
  localparam logic [REG_W-1:0] REG_PC  = 4'd10;

  typedef enum logic [2:0] {
    UK_NOP,
    UK_SET,
    UK_ADD,
    UK_SUB,
    UK_JNZ,
    UK_EVICT
  } uop_kind_t;

  typedef enum logic [1:0] {
    RC_BYTE,
    RC_WIDE,
    RC_PC,
    RC_NONE
  } reg_class_t;

  typedef struct packed {
    uop_kind_t             kind;
    logic [REG_W-1:0]      dest;
    logic [REG_W-1:0]      src;
    logic [DATA_W-1:0]     imm;
    logic [REASON_W-1:0]   reason;
  } uop_t;

  function automatic reg_class_t reg_class(input logic [REG_W-1:0] code);
    reg_class_t rc;
    if (code < REG_EAX) begin
      rc = RC_BYTE;
    end else if (code < REG_PC) begin
      rc = RC_WIDE;
    end else if (code == REG_PC) begin
      rc = RC_PC;
    end else begin
      rc = RC_NONE;
    end
    return rc;
  endfunction

  function automatic logic [BIDX_W-1:0] byte_idx(input logic [REG_W-1:0] code);
    logic [REG_W-1:0] off;
    off = code - REG_AX;
    return off[BIDX_W-1:0];
  endfunction

  function automatic logic [WIDX_W-1:0] wide_idx(input logic [REG_W-1:0] code);
    logic [REG_W-1:0] off;
    off = code - REG_EAX;
    return off[WIDX_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] zext_byte(input logic [BYTE_W-1:0] b);
    return {{(DATA_W-BYTE_W){1'b0}}, b};
  endfunction

endpackage

[src/tcpu_instr_if.sv]
`timescale 1ns / 1ps

interface tcpu_instr_if import tcpu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [REG_W-1:0]  dest_reg;
  logic [REG_W-1:0]  src_reg;
  logic [DATA_W-1:0] immediate;

  modport source (output valid, output operation, output dest_reg, output src_reg,
                  output immediate, input ready);
  modport sink (input valid, input operation, input dest_reg, input src_reg,
                input immediate, output ready);
endinterface

[src/tcpu_result_if.sv]
`timescale 1ns / 1ps

interface tcpu_result_if import tcpu_pkg::*;;
  logic                valid;
  logic                ready;
  logic                evict;
  logic [REASON_W-1:0] reason;
  logic                pc_modified;
  logic [DATA_W-1:0]   pc_now;

  modport source (output valid, output evict, output reason, output pc_modified,
                  output pc_now, input ready);
  modport sink (input valid, input evict, input reason, input pc_modified,
                input pc_now, output ready);
endinterface

[src/tcpu_front.sv]
`timescale 1ns / 1ps

module tcpu_front import tcpu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tcpu_instr_if.sink instr,
  output logic       uop_valid,
  input  logic       uop_ready,
  output uop_t       uop
);

  logic valid;
  uop_t held;
  uop_t dec;
  logic [OP_W-1:0] op_off;

  assign instr.ready = !valid || uop_ready;
  assign uop_valid   = valid;
  assign uop         = held;

  always_comb begin
    op_off     = instr.operation - OP_SLEEP;
    dec.dest   = instr.dest_reg;
    dec.src    = instr.src_reg;
    dec.imm    = instr.immediate;
    dec.reason = '0;
    case (instr.operation)
      OP_SET: begin
        dec.kind = UK_SET;
      end
      OP_SUM: begin
        dec.kind = UK_ADD;
      end
      OP_SUB: begin
        dec.kind = UK_SUB;
      end
      OP_JNZ: begin
        dec.kind = UK_JNZ;
      end
      default: begin
        if (instr.operation inside {[OP_SLEEP:OP_EXIT]}) begin
          dec.kind   = UK_EVICT;
          dec.reason = op_off[REASON_W-1:0];
        end else begin
          dec.kind = UK_NOP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (instr.ready) begin
      valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      held <= dec;
    end
  end

endmodule

[src/tcpu_queue.sv]
`timescale 1ns / 1ps
`include "toy_cpu_execute_unit_core_assert.svh"

module tcpu_queue import tcpu_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  uop_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output uop_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  uop_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `TCPU_ASSERT_IMPLY(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "queue count above depth")
  `TCPU_ASSERT_NEXT(a_pop_drains, pop && !push, count == $past(count) - 1'b1, "pop lost")

endmodule

[src/tcpu_back.sv]
`timescale 1ns / 1ps
`include "toy_cpu_execute_unit_core_assert.svh"

module tcpu_back import tcpu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  uop_t          q_data,
  tcpu_result_if.source result
);

  logic [BYTE_W-1:0] byte_mem [NUM_BYTE_REGS];
  logic [DATA_W-1:0] wide_mem [NUM_WIDE_REGS];
  logic [NUM_BYTE_REGS-1:0] byte_ok;
  logic [NUM_WIDE_REGS-1:0] wide_ok;
  logic [DATA_W-1:0] pc;

  logic              s1_valid;
  uop_t              s1_uop;
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;

  logic                out_valid;
  logic                out_evict;
  logic [REASON_W-1:0] out_reason;
  logic                out_pc_mod;
  logic [DATA_W-1:0]   out_pc_now;

  logic              fire;
  logic              take;
  logic              wr_en;
  logic [DATA_W-1:0] wr_val;
  logic              pc_mod;
  logic [DATA_W-1:0] pc_next;
  logic [DATA_W-1:0] pc_fwd;
  reg_class_t        dcls;
  logic              wr_byte;
  logic              wr_wide;

  assign fire    = s1_valid && (!out_valid || result.ready);
  assign q_ready = !s1_valid || fire;
  assign take    = q_valid && q_ready;

  assign result.valid       = out_valid;
  assign result.evict       = out_evict;
  assign result.reason      = out_reason;
  assign result.pc_modified = out_pc_mod;
  assign result.pc_now      = out_pc_now;

  always_comb begin
    wr_en   = 1'b0;
    wr_val  = '0;
    pc_mod  = 1'b0;
    pc_next = pc;
    dcls    = reg_class(s1_uop.dest);
    case (s1_uop.kind)
      UK_SET: begin
        wr_en  = 1'b1;
        wr_val = s1_uop.imm;
      end
      UK_ADD: begin
        wr_en  = 1'b1;
        wr_val = opa + opb;
      end
      UK_SUB: begin
        wr_en  = 1'b1;
        wr_val = opa - opb;
      end
      UK_JNZ: begin
        if (opa != '0) begin
          pc_next = s1_uop.imm;
          pc_mod  = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (wr_en && dcls == RC_PC) begin
      pc_next = wr_val;
    end
    wr_byte = fire && wr_en && dcls == RC_BYTE;
    wr_wide = fire && wr_en && dcls == RC_WIDE;
    pc_fwd  = fire ? pc_next : pc;
  end

  // register file writes, valid bits stand for the zero reset value
  always_ff @(posedge clk) begin
    if (wr_byte) begin
      byte_mem[byte_idx(s1_uop.dest)] <= wr_val[BYTE_W-1:0];
    end
    if (wr_wide) begin
      wide_mem[wide_idx(s1_uop.dest)] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_ok <= '0;
      wide_ok <= '0;
      pc      <= '0;
    end else begin
      if (wr_byte) begin
        byte_ok[byte_idx(s1_uop.dest)] <= 1'b1;
      end
      if (wr_wide) begin
        wide_ok[wide_idx(s1_uop.dest)] <= 1'b1;
      end
      if (fire) begin
        pc <= pc_next;
      end
    end
  end

  // operand read, the write of the retiring instruction is forwarded
  always_ff @(posedge clk) begin
    if (take) begin
      case (reg_class(q_data.dest))
        RC_BYTE: begin
          if (wr_byte && byte_idx(s1_uop.dest) == byte_idx(q_data.dest)) begin
            opa <= zext_byte(wr_val[BYTE_W-1:0]);
          end else if (byte_ok[byte_idx(q_data.dest)]) begin
            opa <= zext_byte(byte_mem[byte_idx(q_data.dest)]);
          end else begin
            opa <= '0;
          end
        end
        RC_WIDE: begin
          if (wr_wide && wide_idx(s1_uop.dest) == wide_idx(q_data.dest)) begin
            opa <= wr_val;
          end else if (wide_ok[wide_idx(q_data.dest)]) begin
            opa <= wide_mem[wide_idx(q_data.dest)];
          end else begin
            opa <= '0;
          end
        end
        RC_PC: begin
          opa <= pc_fwd;
        end
        default: begin
          opa <= '0;
        end
      endcase
      case (reg_class(q_data.src))
        RC_BYTE: begin
          if (wr_byte && byte_idx(s1_uop.dest) == byte_idx(q_data.src)) begin
            opb <= zext_byte(wr_val[BYTE_W-1:0]);
          end else if (byte_ok[byte_idx(q_data.src)]) begin
            opb <= zext_byte(byte_mem[byte_idx(q_data.src)]);
          end else begin
            opb <= '0;
          end
        end
        RC_WIDE: begin
          if (wr_wide && wide_idx(s1_uop.dest) == wide_idx(q_data.src)) begin
            opb <= wr_val;
          end else if (wide_ok[wide_idx(q_data.src)]) begin
            opb <= wide_mem[wide_idx(q_data.src)];
          end else begin
            opb <= '0;
          end
        end
        RC_PC: begin
          opb <= pc_fwd;
        end
        default: begin
          opb <= '0;
        end
      endcase
      s1_uop <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_ready) begin
        s1_valid <= q_valid;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_evict  <= s1_uop.kind == UK_EVICT;
      out_reason <= s1_uop.reason;
      out_pc_mod <= pc_mod;
      out_pc_now <= pc_next;
    end
  end

  `TCPU_ASSERT_IMPLY(a_jump_not_evict, out_valid && out_pc_mod, !out_evict, "jump with evict")
  `TCPU_ASSERT_IMPLY(a_reason_idle, out_valid && !out_evict, out_reason == '0, "stray reason")
  `TCPU_ASSERT_NEXT(a_pc_reported, fire, out_pc_now == pc, "reported pc differs from pc")

endmodule

[src/toy_cpu_execute_unit_core.sv]
// path from the input transfer to a valid result:
// decode register, instruction queue, operand read, result register
// throughput: one instruction per cycle, held back only by result stalls
// reset: synchronous, clears all registers and the pc to zero and empties
// the queue; no clearing pass, an instruction may follow reset at once
`timescale 1ns / 1ps

module toy_cpu_execute_unit_core import tcpu_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  tcpu_instr_if.sink    instr,
  tcpu_result_if.source result
);

  logic f_valid;
  logic f_ready;
  uop_t f_uop;
  logic q_valid;
  logic q_ready;
  uop_t q_uop;

  tcpu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .instr     (instr),
    .uop_valid (f_valid),
    .uop_ready (f_ready),
    .uop       (f_uop)
  );

  tcpu_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_uop),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_uop)
  );

  tcpu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_uop),
    .result  (result)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import tcpu_pkg::*;

  localparam logic [OP_W-1:0] OP_STDOUT       = 4'd5;
  localparam logic [OP_W-1:0] OP_STDIN        = 4'd6;
  localparam logic [OP_W-1:0] OP_MUTEX_CREATE = 4'd7;
  localparam logic [OP_W-1:0] OP_MUTEX_LOCK   = 4'd8;
  localparam logic [OP_W-1:0] OP_MUTEX_UNLOCK = 4'd9;
  localparam logic [OP_W-1:0] OP_NOP          = 4'd11;
  localparam logic [OP_W-1:0] OP_LAST         = 4'd15;

  localparam logic [REG_W-1:0] REG_DX   = 4'd3;
  localparam logic [REG_W-1:0] REG_SI   = 4'd8;
  localparam logic [REG_W-1:0] REG_DI   = 4'd9;
  localparam logic [REG_W-1:0] REG_UNK  = 4'd11;
  localparam logic [REG_W-1:0] REG_LAST = 4'd15;

  localparam int NUM_RANDOM = 1280;
  localparam int LONG_HOLD  = 80;

  typedef struct packed {
    logic                evict;
    logic [REASON_W-1:0] reason;
    logic                pc_modified;
    logic [DATA_W-1:0]   pc_now;
  } exec_result_t;

  class exec_scoreboard;
    logic [BYTE_W-1:0] byte_regs [NUM_BYTE_REGS];
    logic [DATA_W-1:0] wide_regs [NUM_WIDE_REGS];
    logic [DATA_W-1:0] prog_cnt;
    exec_result_t      pending [$];
    int                errors;

    function new();
      foreach (byte_regs[i]) byte_regs[i] = '0;
      foreach (wide_regs[i]) wide_regs[i] = '0;
      prog_cnt = '0;
      errors   = 0;
    endfunction

    function logic [DATA_W-1:0] read_reg(input logic [REG_W-1:0] code);
      logic [DATA_W-1:0] val;
      val = '0;
      if (code < REG_EAX) begin
        val = {{(DATA_W-BYTE_W){1'b0}}, byte_regs[code - REG_AX]};
      end else if (code < REG_PC) begin
        val = wide_regs[code - REG_EAX];
      end else if (code == REG_PC) begin
        val = prog_cnt;
      end
      return val;
    endfunction

    function void write_reg(input logic [REG_W-1:0] code, input logic [DATA_W-1:0] val);
      if (code < REG_EAX) begin
        byte_regs[code - REG_AX] = val[BYTE_W-1:0];
      end else if (code < REG_PC) begin
        wide_regs[code - REG_EAX] = val;
      end else if (code == REG_PC) begin
        prog_cnt = val;
      end
    endfunction

    // executes one transferred instruction and queues its outcome
    function void note_instr(input logic [OP_W-1:0] op, input logic [REG_W-1:0] dst,
                             input logic [REG_W-1:0] src, input logic [DATA_W-1:0] imm);
      exec_result_t    r;
      logic [OP_W-1:0] code_off;
      r = '0;
      case (op)
        OP_SET: write_reg(dst, imm);
        OP_SUM: write_reg(dst, read_reg(dst) + read_reg(src));
        OP_SUB: write_reg(dst, read_reg(dst) - read_reg(src));
        OP_JNZ: begin
          if (read_reg(dst) != '0) begin
            prog_cnt      = imm;
            r.pc_modified = 1'b1;
          end
        end
        default: begin
          if (op >= OP_SLEEP && op <= OP_EXIT) begin
            code_off = op - OP_SLEEP;
            r.evict  = 1'b1;
            r.reason = code_off[REASON_W-1:0];
          end
        end
      endcase
      r.pc_now = prog_cnt;
      pending.push_back(r);
    endfunction

    function void check_result(input exec_result_t act);
      exec_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result transfer with nothing pending: pc_now %08h", act.pc_now);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (act.evict !== exp_r.evict) begin
        $error("evict: expected %0d, actual %0d", exp_r.evict, act.evict);
        errors++;
      end
      if (act.reason !== exp_r.reason) begin
        $error("reason: expected %0d, actual %0d", exp_r.reason, act.reason);
        errors++;
      end
      if (act.pc_modified !== exp_r.pc_modified) begin
        $error("pc_modified: expected %0d, actual %0d", exp_r.pc_modified, act.pc_modified);
        errors++;
      end
      if (act.pc_now !== exp_r.pc_now) begin
        $error("pc_now: expected %08h, actual %08h", exp_r.pc_now, act.pc_now);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   hold_req = 1'b0;

  exec_scoreboard sb;

  tcpu_instr_if  instr_if ();
  tcpu_result_if result_if ();

  toy_cpu_execute_unit_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_if.sink),
    .result (result_if.source)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (instr_if.valid && instr_if.ready) begin
        sb.note_instr(instr_if.operation, instr_if.dest_reg, instr_if.src_reg,
                      instr_if.immediate);
      end
      if (result_if.valid && result_if.ready) begin
        sb.check_result({result_if.evict, result_if.reason, result_if.pc_modified,
                         result_if.pc_now});
      end
    end
  end

  task automatic send_instr(input logic [OP_W-1:0] op, input logic [REG_W-1:0] dst,
                            input logic [REG_W-1:0] src, input logic [DATA_W-1:0] imm);
    @(negedge clk);
    instr_if.valid     <= 1'b1;
    instr_if.operation <= op;
    instr_if.dest_reg  <= dst;
    instr_if.src_reg   <= src;
    instr_if.immediate <= imm;
    do @(posedge clk); while (!instr_if.ready);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      instr_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [REG_W-1:0] rand_reg();
    if ($urandom_range(0, 99) < 88) return REG_W'($urandom_range(REG_AX, REG_PC));
    return REG_W'($urandom_range(REG_UNK, REG_LAST));
  endfunction

  function automatic logic [OP_W-1:0] rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return OP_SET;
    if (r < 38) return OP_SUM;
    if (r < 56) return OP_SUB;
    if (r < 72) return OP_JNZ;
    if (r < 92) return OP_W'($urandom_range(OP_SLEEP, OP_EXIT));
    return OP_W'($urandom_range(OP_NOP, OP_LAST));
  endfunction

  function automatic logic [DATA_W-1:0] rand_imm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 80) return '0;
    if (r < 90) return '1;
    return $urandom_range(0, 255);
  endfunction

  // result side stalls, with an occasional long hold-off on request
  initial begin : result_sink
    int stall;
    int run;
    int r;
    result_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end else if (r < 50) begin
        stall = 0;
      end else if (r < 90) begin
        stall = $urandom_range(1, 3);
      end else begin
        stall = $urandom_range(8, 30);
      end
      run = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4) : $urandom_range(10, 40);
      repeat (stall) begin
        @(negedge clk);
        result_if.ready <= 1'b0;
      end
      repeat (run) begin
        @(negedge clk);
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    sb = new();
    instr_if.valid     = 1'b0;
    instr_if.operation = OP_SET;
    instr_if.dest_reg  = REG_AX;
    instr_if.src_reg   = REG_AX;
    instr_if.immediate = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, wraps, pc as operand, unknown codes, every opcode from SET to EXIT
    send_instr(OP_SET, REG_AX, REG_AX, 32'hFFFF_FFFF);
    send_instr(OP_SET, REG_EAX, REG_AX, 32'hFFFF_FFFF);
    send_instr(OP_SUM, REG_AX, REG_EAX, 32'h0);
    send_instr(OP_SUM, REG_EAX, REG_EAX, 32'h0);
    send_instr(OP_SET, REG_SI, REG_AX, 32'h0);
    send_instr(OP_SUB, REG_SI, REG_EAX, 32'h0);
    send_instr(OP_SET, REG_DX, REG_AX, 32'h0000_0100);
    send_instr(OP_JNZ, REG_DX, REG_AX, 32'h0000_1234);
    send_instr(OP_JNZ, REG_AX, REG_AX, 32'hDEAD_BEEF);
    send_instr(OP_SET, REG_PC, REG_AX, 32'h8000_0000);
    send_instr(OP_SUM, REG_PC, REG_EAX, 32'h0);
    send_instr(OP_SUB, REG_DI, REG_PC, 32'h0);
    send_instr(OP_JNZ, REG_PC, REG_AX, 32'hFFFF_FFFF);
    send_instr(OP_SET, REG_UNK, REG_AX, 32'hAAAA_5555);
    send_instr(OP_SUM, REG_EAX, REG_LAST, 32'h0);
    send_instr(OP_JNZ, REG_LAST, REG_AX, 32'h5555_AAAA);
    send_instr(OP_STDOUT, REG_AX, REG_AX, 32'h0);
    for (int k = OP_SLEEP; k <= OP_EXIT; k++) begin
      send_instr(k[OP_W-1:0], rand_reg(), rand_reg(), $urandom);
    end
    send_instr(OP_NOP, REG_EAX, REG_SI, 32'h1234_5678);
    send_instr(OP_LAST, REG_LAST, REG_LAST, 32'hFFFF_FFFF);
    idle_gap(1);

    hold_req = 1'b1;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) hold_req = 1'b1;
      send_instr(rand_op(), rand_reg(), rand_reg(), rand_imm());
      // back-to-back bursts so stretches without any gaps occur
      idle_gap((i % 200 < 40) ? 0 : pick_gap());
    end
    @(negedge clk);
    instr_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tcpu_pkg.sv
src/tcpu_instr_if.sv
src/tcpu_result_if.sv
src/tcpu_front.sv
src/tcpu_queue.sv
src/tcpu_back.sv
src/toy_cpu_execute_unit_core.sv
verif/tb_top.sv
